/* rtl/kmeans_lloyd_clustering_top_macros.svh */
// Assertion macros used by the block's top-level RTL file.
`ifndef KMEANS_LLOYD_CLUSTERING_TOP_MACROS_SVH
`define KMEANS_LLOYD_CLUSTERING_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define KLC_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("klc assertion failed");

`define KLC_ASSERT_NXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("klc assertion failed");

`else

`define KLC_ASSERT_IMP(label, clk, rst_n, a, b)
`define KLC_ASSERT_NXT(label, clk, rst_n, a, b)

`endif

`endif

/* rtl/klc_pkg.sv */
package klc_pkg;

    localparam int MAX_POINTS   = 1024;
    localparam int MAX_CLUSTERS = 16;
    localparam int MAX_DIMS     = 128;

    localparam int P_W  = $clog2(MAX_POINTS);
    localparam int C_W  = $clog2(MAX_CLUSTERS);
    localparam int D_W  = $clog2(MAX_DIMS);
    localparam int PT_AW = P_W + D_W;
    localparam int CT_AW = C_W + D_W;
    localparam int PT_DEPTH = MAX_POINTS * MAX_DIMS;
    localparam int CT_DEPTH = MAX_CLUSTERS * MAX_DIMS;

    localparam int VAL_W  = 16;
    localparam int SUM_W  = 32;
    localparam int CNT_W  = 11;
    localparam int DIFF_W = 17;
    localparam int SQR_W  = 34;
    localparam int DIST_W = 40;
    localparam int ROOT_W = 21;
    localparam int SH_W   = 24;

    localparam int K_W    = 5;
    localparam int ND_W   = 8;
    localparam int NP_W   = 11;
    localparam int THR_W  = 16;
    localparam int ITER_W = 8;

    localparam logic [SH_W-1:0] DEATH_SHIFT = SH_W'(100000);

    localparam logic [1:0] CMD_LOAD_PT = 2'd0;
    localparam logic [1:0] CMD_LOAD_CT = 2'd1;
    localparam logic [1:0] CMD_RUN     = 2'd2;
    localparam logic [1:0] CMD_READ    = 2'd3;

    localparam logic [2:0] REG_NUM_CLUSTERS   = 3'd0;
    localparam logic [2:0] REG_NUM_DIMS       = 3'd1;
    localparam logic [2:0] REG_NUM_POINTS     = 3'd2;
    localparam logic [2:0] REG_STOP_THRESHOLD = 3'd3;
    localparam logic [2:0] REG_MAX_ITERATIONS = 3'd4;

    typedef logic signed [VAL_W-1:0] t_val;

endpackage

/* rtl/klc_ram.sv */
module klc_ram #(
    parameter int W = 16,
    parameter int D = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/klc_div.sv */
module klc_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [klc_pkg::SUM_W-1:0]   i_dividend,
    input  logic [klc_pkg::CNT_W-1:0]          i_divisor,
    output logic                               o_done,
    output klc_pkg::t_val                      o_quot
);

    localparam int STEP_W = $clog2(klc_pkg::SUM_W);

    logic                        r_busy;
    logic                        r_done;
    logic [STEP_W-1:0]           r_step;
    logic                        r_neg;
    logic [klc_pkg::SUM_W-1:0]   r_num;
    logic [klc_pkg::CNT_W-1:0]   r_rem;
    logic [klc_pkg::CNT_W-1:0]   r_den;
    logic [klc_pkg::CNT_W:0]     w_trial;
    logic                        w_ge;
    logic [klc_pkg::CNT_W:0]     w_rem;
    logic [klc_pkg::VAL_W-1:0]   w_mag;

    always_comb begin
        w_trial = {r_rem, r_num[klc_pkg::SUM_W-1]};
        w_ge    = w_trial >= {1'b0, r_den};
        w_rem   = w_ge ? (w_trial - {1'b0, r_den}) : w_trial;
        w_mag   = r_num[klc_pkg::VAL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(klc_pkg::SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[klc_pkg::SUM_W-1];
            r_num <= i_dividend[klc_pkg::SUM_W-1] ? (~i_dividend + 1'b1) : i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_num <= {r_num[klc_pkg::SUM_W-2:0], w_ge};
            r_rem <= w_rem[klc_pkg::CNT_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? klc_pkg::t_val'(~w_mag + 1'b1) : klc_pkg::t_val'(w_mag);

endmodule

/* rtl/klc_sqrt.sv */
module klc_sqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [klc_pkg::DIST_W-1:0]   i_radicand,
    output logic                         o_done,
    output logic [klc_pkg::ROOT_W-1:0]   o_root
);

    localparam int STEPS  = klc_pkg::DIST_W / 2;
    localparam int STEP_W = $clog2(STEPS);

    logic                         r_busy;
    logic                         r_done;
    logic [STEP_W-1:0]            r_step;
    logic [klc_pkg::DIST_W-1:0]   r_s;
    logic [klc_pkg::DIST_W:0]     r_r;
    logic [klc_pkg::DIST_W-1:0]   r_bit;
    logic [klc_pkg::DIST_W:0]     w_trial;
    logic                         w_ge;
    logic                         w_up;

    always_comb begin
        w_trial = r_r + {1'b0, r_bit};
        w_ge    = {1'b0, r_s} >= w_trial;
        w_up    = {1'b0, r_s} > r_r;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_s   <= i_radicand;
            r_r   <= '0;
            r_bit <= klc_pkg::DIST_W'(1) << (klc_pkg::DIST_W - 2);
        end else if (r_busy) begin
            if (w_ge) begin
                r_s <= r_s - w_trial[klc_pkg::DIST_W-1:0];
                r_r <= (r_r >> 1) + {1'b0, r_bit};
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_r[klc_pkg::ROOT_W-1:0] + klc_pkg::ROOT_W'(w_up);

endmodule

/* rtl/kmeans_lloyd_clustering_top.sv */
// Channel   Direction  Handshake                        Payload
// s_axis    in         i_s_axis_tvalid/o_s_axis_tready  tdata: indices, value; tuser: command
// m_axis    out        o_m_axis_tvalid/i_m_axis_tready  tdata: centre_value, iterations, ...
// cfg       in         i_cfg_valid/o_cfg_ready          i_cfg_index, i_cfg_data
//
// Loads write their store as they are taken; a read passes through S_RDWAIT and S_EMIT.
// Reset is synchronous, active low; the stores are not cleared.
// Input is not taken while a run or read is in flight; a finished read or run
// holds until the output register is free, while a waiting beat does not block loads.
`include "kmeans_lloyd_clustering_top_macros.svh"

module kmeans_lloyd_clustering_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // point_index[9:0], centre_index[13:10], dim_index[20:14], value[36:21], zero[39:37]
    input  logic [39:0] i_s_axis_tdata,
    // command[1:0]
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // centre_value[15:0], iterations[23:16], surviving_clusters[28:24], converged[29]
    output logic [31:0] o_m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int S_W = 5;
    localparam logic [S_W-1:0] S_IDLE    = 5'd0;
    localparam logic [S_W-1:0] S_RDWAIT  = 5'd1;
    localparam logic [S_W-1:0] S_EMIT    = 5'd2;
    localparam logic [S_W-1:0] S_CLR     = 5'd3;
    localparam logic [S_W-1:0] S_CSEL    = 5'd4;
    localparam logic [S_W-1:0] S_DRD     = 5'd5;
    localparam logic [S_W-1:0] S_DSUB    = 5'd6;
    localparam logic [S_W-1:0] S_DMUL    = 5'd7;
    localparam logic [S_W-1:0] S_DACC    = 5'd8;
    localparam logic [S_W-1:0] S_DPICK   = 5'd9;
    localparam logic [S_W-1:0] S_ARD     = 5'd10;
    localparam logic [S_W-1:0] S_AWR     = 5'd11;
    localparam logic [S_W-1:0] S_NEXTP   = 5'd12;
    localparam logic [S_W-1:0] S_UCHK    = 5'd13;
    localparam logic [S_W-1:0] S_URD     = 5'd14;
    localparam logic [S_W-1:0] S_UDIV0   = 5'd15;
    localparam logic [S_W-1:0] S_UDIV    = 5'd16;
    localparam logic [S_W-1:0] S_UMUL    = 5'd17;
    localparam logic [S_W-1:0] S_UACC    = 5'd18;
    localparam logic [S_W-1:0] S_USQ0    = 5'd19;
    localparam logic [S_W-1:0] S_USQRT   = 5'd20;
    localparam logic [S_W-1:0] S_ITEREND = 5'd21;
    localparam logic [S_W-1:0] S_COMPACT = 5'd22;

    localparam int C_CW = klc_pkg::C_W + 1;
    localparam int E_CW = klc_pkg::D_W + 1;
    localparam int P_CW = klc_pkg::P_W + 1;

    logic [S_W-1:0]                    r_state;
    logic [klc_pkg::K_W-1:0]           r_num_clusters;
    logic [klc_pkg::ND_W-1:0]          r_num_dims;
    logic [klc_pkg::NP_W-1:0]          r_num_points;
    logic [klc_pkg::THR_W-1:0]         r_stop_threshold;
    logic [klc_pkg::ITER_W-1:0]        r_max_iterations;

    logic [klc_pkg::CT_AW-1:0]         r_clr;
    logic [P_CW-1:0]                   r_p;
    logic [C_CW-1:0]                   r_c;
    logic [E_CW-1:0]                   r_e;
    logic [klc_pkg::C_W-1:0]           r_best;
    logic                              r_best_v;
    logic [klc_pkg::DIST_W-1:0]        r_best_d;
    logic [klc_pkg::DIST_W-1:0]        r_dist;
    logic signed [klc_pkg::DIFF_W-1:0] r_diff;
    logic [klc_pkg::SQR_W-1:0]         r_sqr;
    logic [klc_pkg::DIST_W-1:0]        r_sq;
    logic [klc_pkg::SH_W-1:0]          r_shift;
    klc_pkg::t_val                     r_old;
    logic [klc_pkg::ITER_W-1:0]        r_iter;
    logic                              r_conv;
    logic [klc_pkg::MAX_CLUSTERS-1:0]  r_alive;
    logic [klc_pkg::CNT_W-1:0]         r_cnt [klc_pkg::MAX_CLUSTERS];
    logic [klc_pkg::C_W-1:0]           r_map [klc_pkg::MAX_CLUSTERS];
    logic [C_CW-1:0]                   r_surv;
    logic                              r_rd_ok;
    klc_pkg::t_val                     r_res_cv;
    logic                              r_out_valid;
    logic [31:0]                       r_out_data;

    logic [klc_pkg::K_W-1:0]           w_k;
    logic [klc_pkg::ND_W-1:0]          w_d;
    logic [klc_pkg::NP_W-1:0]          w_n;
    logic [klc_pkg::ITER_W-1:0]        w_lim;
    logic                              w_in_acc;
    logic                              w_emit;
    logic [1:0]                        w_cmd;
    logic [klc_pkg::P_W-1:0]           w_pi;
    logic [klc_pkg::C_W-1:0]           w_ci;
    logic [klc_pkg::D_W-1:0]           w_di;
    klc_pkg::t_val                     w_val;
    logic                              w_rd_ok;
    logic                              w_e_last;
    logic [klc_pkg::ITER_W-1:0]        w_iter_nx;
    logic                              w_stable;

    logic                              w_pt_we;
    logic [klc_pkg::PT_AW-1:0]         w_pt_waddr;
    logic [klc_pkg::PT_AW-1:0]         w_pt_raddr;
    klc_pkg::t_val                     w_pt_rdata;
    logic                              w_ct_we;
    logic [klc_pkg::CT_AW-1:0]         w_ct_waddr;
    klc_pkg::t_val                     w_ct_wdata;
    logic [klc_pkg::CT_AW-1:0]         w_ct_raddr;
    klc_pkg::t_val                     w_ct_rdata;
    logic                              w_sm_we;
    logic [klc_pkg::CT_AW-1:0]         w_sm_waddr;
    logic signed [klc_pkg::SUM_W-1:0]  w_sm_wdata;
    logic [klc_pkg::CT_AW-1:0]         w_sm_addr;
    logic signed [klc_pkg::SUM_W-1:0]  w_sm_rdata;

    logic                              w_div_done;
    klc_pkg::t_val                     w_quot;
    logic                              w_sqrt_done;
    logic [klc_pkg::ROOT_W-1:0]        w_root;

    always_comb begin
        w_k   = (r_num_clusters == '0) ? klc_pkg::K_W'(1)
              : (r_num_clusters > klc_pkg::K_W'(klc_pkg::MAX_CLUSTERS))
              ? klc_pkg::K_W'(klc_pkg::MAX_CLUSTERS) : r_num_clusters;
        w_d   = (r_num_dims == '0) ? klc_pkg::ND_W'(1)
              : (r_num_dims > klc_pkg::ND_W'(klc_pkg::MAX_DIMS))
              ? klc_pkg::ND_W'(klc_pkg::MAX_DIMS) : r_num_dims;
        w_n   = (r_num_points == '0) ? klc_pkg::NP_W'(1)
              : (r_num_points > klc_pkg::NP_W'(klc_pkg::MAX_POINTS))
              ? klc_pkg::NP_W'(klc_pkg::MAX_POINTS) : r_num_points;
        w_lim = (r_max_iterations == '0) ? klc_pkg::ITER_W'(1) : r_max_iterations;

        w_in_acc = i_s_axis_tvalid && o_s_axis_tready;
        w_emit   = (r_state == S_EMIT) && (!r_out_valid || i_m_axis_tready);
        w_cmd    = i_s_axis_tuser;
        w_pi     = i_s_axis_tdata[9:0];
        w_ci     = i_s_axis_tdata[13:10];
        w_di     = i_s_axis_tdata[20:14];
        w_val    = klc_pkg::t_val'(i_s_axis_tdata[36:21]);
        w_rd_ok  = ({1'b0, w_ci} < r_surv) && ({1'b0, w_di} < w_d);

        w_e_last  = ({1'b0, r_e} == {1'b0, w_d} - 9'd1);
        w_iter_nx = r_iter + 1'b1;
        w_stable  = r_shift <= klc_pkg::SH_W'(r_stop_threshold * w_k);
    end

    always_comb begin
        w_pt_we    = w_in_acc && (w_cmd == klc_pkg::CMD_LOAD_PT);
        w_pt_waddr = {w_pi, w_di};
        w_pt_raddr = {r_p[klc_pkg::P_W-1:0], r_e[klc_pkg::D_W-1:0]};

        w_ct_we    = 1'b0;
        w_ct_waddr = {r_c[klc_pkg::C_W-1:0], r_e[klc_pkg::D_W-1:0]};
        w_ct_wdata = w_quot;
        w_ct_raddr = {r_c[klc_pkg::C_W-1:0], r_e[klc_pkg::D_W-1:0]};
        if (r_state == S_IDLE) begin
            w_ct_we    = w_in_acc && (w_cmd == klc_pkg::CMD_LOAD_CT);
            w_ct_waddr = {w_ci, w_di};
            w_ct_wdata = w_val;
            w_ct_raddr = {r_map[w_ci], w_di};
        end else if (r_state == S_UDIV) begin
            w_ct_we = w_div_done;
        end

        w_sm_we    = 1'b0;
        w_sm_waddr = {r_c[klc_pkg::C_W-1:0], r_e[klc_pkg::D_W-1:0]};
        w_sm_wdata = w_sm_rdata + klc_pkg::SUM_W'(w_pt_rdata);
        w_sm_addr  = {r_c[klc_pkg::C_W-1:0], r_e[klc_pkg::D_W-1:0]};
        if (r_state == S_CLR) begin
            w_sm_we    = 1'b1;
            w_sm_waddr = r_clr;
            w_sm_wdata = '0;
        end else if (r_state == S_AWR) begin
            w_sm_we = 1'b1;
        end
    end

    klc_ram #(.W(klc_pkg::VAL_W), .D(klc_pkg::PT_DEPTH)) u_point_ram (
        .i_clk   (i_clk),
        .i_we    (w_pt_we),
        .i_waddr (w_pt_waddr),
        .i_wdata (w_val),
        .i_raddr (w_pt_raddr),
        .o_rdata (w_pt_rdata)
    );

    klc_ram #(.W(klc_pkg::VAL_W), .D(klc_pkg::CT_DEPTH)) u_centre_ram (
        .i_clk   (i_clk),
        .i_we    (w_ct_we),
        .i_waddr (w_ct_waddr),
        .i_wdata (w_ct_wdata),
        .i_raddr (w_ct_raddr),
        .o_rdata (w_ct_rdata)
    );

    klc_ram #(.W(klc_pkg::SUM_W), .D(klc_pkg::CT_DEPTH)) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (w_sm_we),
        .i_waddr (w_sm_waddr),
        .i_wdata (w_sm_wdata),
        .i_raddr (w_sm_addr),
        .o_rdata (w_sm_rdata)
    );

    klc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_UDIV0),
        .i_dividend (w_sm_rdata),
        .i_divisor  (r_cnt[r_c[klc_pkg::C_W-1:0]]),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    klc_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_USQ0),
        .i_radicand (r_sq),
        .o_done     (w_sqrt_done),
        .o_root     (w_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_num_clusters   <= klc_pkg::K_W'(8);
            r_num_dims       <= klc_pkg::ND_W'(128);
            r_num_points     <= klc_pkg::NP_W'(1024);
            r_stop_threshold <= klc_pkg::THR_W'(256);
            r_max_iterations <= klc_pkg::ITER_W'(100);
            r_iter           <= '0;
            r_conv           <= 1'b0;
            r_surv           <= '0;
            r_alive          <= '1;
            r_best_v         <= 1'b0;
            r_out_valid      <= 1'b0;
            for (int i = 0; i < klc_pkg::MAX_CLUSTERS; i++) begin
                r_cnt[i] <= '0;
                r_map[i] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    klc_pkg::REG_NUM_CLUSTERS:   r_num_clusters   <= i_cfg_data[4:0];
                    klc_pkg::REG_NUM_DIMS:       r_num_dims       <= i_cfg_data[7:0];
                    klc_pkg::REG_NUM_POINTS:     r_num_points     <= i_cfg_data[10:0];
                    klc_pkg::REG_STOP_THRESHOLD: r_stop_threshold <= i_cfg_data;
                    klc_pkg::REG_MAX_ITERATIONS: r_max_iterations <= i_cfg_data[7:0];
                    default: ;
                endcase
            end

            if (w_emit) begin
                r_out_valid <= 1'b1;
                r_out_data  <= {2'b00, r_conv, r_surv, r_iter, r_res_cv};
            end else if (o_m_axis_tvalid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (w_cmd == klc_pkg::CMD_RUN) begin
                            for (int i = 0; i < klc_pkg::MAX_CLUSTERS; i++) begin
                                r_alive[i] <= (klc_pkg::K_W'(i) < w_k);
                            end
                            r_iter  <= '0;
                            r_clr   <= '0;
                            r_state <= S_CLR;
                        end else if (w_cmd == klc_pkg::CMD_READ) begin
                            r_rd_ok <= w_rd_ok;
                            r_state <= S_RDWAIT;
                        end
                    end
                end
                S_RDWAIT: begin
                    r_res_cv <= r_rd_ok ? w_ct_rdata : '0;
                    r_state  <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_emit) begin
                        r_state <= S_IDLE;
                    end
                end
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == klc_pkg::CT_AW'(klc_pkg::CT_DEPTH - 1)) begin
                        for (int i = 0; i < klc_pkg::MAX_CLUSTERS; i++) begin
                            r_cnt[i] <= '0;
                        end
                        r_p      <= '0;
                        r_c      <= '0;
                        r_best_v <= 1'b0;
                        r_shift  <= '0;
                        r_state  <= S_CSEL;
                    end
                end
                S_CSEL: begin
                    r_e    <= '0;
                    r_dist <= '0;
                    if ({1'b0, r_c} == {1'b0, w_k}) begin
                        if (r_best_v) begin
                            r_c     <= {1'b0, r_best};
                            r_state <= S_ARD;
                        end else begin
                            r_state <= S_NEXTP;
                        end
                    end else if (!r_alive[r_c[klc_pkg::C_W-1:0]]) begin
                        r_c <= r_c + 1'b1;
                    end else begin
                        r_state <= S_DRD;
                    end
                end
                S_DRD: begin
                    r_state <= S_DSUB;
                end
                S_DSUB: begin
                    r_diff  <= klc_pkg::DIFF_W'(w_pt_rdata) - klc_pkg::DIFF_W'(w_ct_rdata);
                    r_state <= S_DMUL;
                end
                S_DMUL: begin
                    r_sqr   <= klc_pkg::SQR_W'(r_diff * r_diff);
                    r_state <= S_DACC;
                end
                S_DACC: begin
                    r_dist <= r_dist + klc_pkg::DIST_W'(r_sqr);
                    if (w_e_last) begin
                        r_state <= S_DPICK;
                    end else begin
                        r_e     <= r_e + 1'b1;
                        r_state <= S_DRD;
                    end
                end
                S_DPICK: begin
                    if (!r_best_v || (r_dist < r_best_d)) begin
                        r_best_v <= 1'b1;
                        r_best   <= r_c[klc_pkg::C_W-1:0];
                        r_best_d <= r_dist;
                    end
                    r_c     <= r_c + 1'b1;
                    r_state <= S_CSEL;
                end
                S_ARD: begin
                    r_state <= S_AWR;
                end
                S_AWR: begin
                    if (w_e_last) begin
                        r_state <= S_NEXTP;
                    end else begin
                        r_e     <= r_e + 1'b1;
                        r_state <= S_ARD;
                    end
                end
                S_NEXTP: begin
                    if (r_best_v) begin
                        r_cnt[r_c[klc_pkg::C_W-1:0]] <= r_cnt[r_c[klc_pkg::C_W-1:0]] + 1'b1;
                    end
                    r_best_v <= 1'b0;
                    r_c      <= '0;
                    if ({1'b0, r_p} == {1'b0, w_n} - 12'd1) begin
                        r_state <= S_UCHK;
                    end else begin
                        r_p     <= r_p + 1'b1;
                        r_state <= S_CSEL;
                    end
                end
                S_UCHK: begin
                    r_e  <= '0;
                    r_sq <= '0;
                    if ({1'b0, r_c} == {1'b0, w_k}) begin
                        r_state <= S_ITEREND;
                    end else if (!r_alive[r_c[klc_pkg::C_W-1:0]]) begin
                        r_c <= r_c + 1'b1;
                    end else if (r_cnt[r_c[klc_pkg::C_W-1:0]] == '0) begin
                        r_alive[r_c[klc_pkg::C_W-1:0]] <= 1'b0;
                        r_shift <= r_shift + klc_pkg::DEATH_SHIFT;
                        r_c     <= r_c + 1'b1;
                    end else begin
                        r_state <= S_URD;
                    end
                end
                S_URD: begin
                    r_state <= S_UDIV0;
                end
                S_UDIV0: begin
                    r_old   <= w_ct_rdata;
                    r_state <= S_UDIV;
                end
                S_UDIV: begin
                    if (w_div_done) begin
                        r_diff  <= klc_pkg::DIFF_W'(w_quot) - klc_pkg::DIFF_W'(r_old);
                        r_state <= S_UMUL;
                    end
                end
                S_UMUL: begin
                    r_sqr   <= klc_pkg::SQR_W'(r_diff * r_diff);
                    r_state <= S_UACC;
                end
                S_UACC: begin
                    r_sq <= r_sq + klc_pkg::DIST_W'(r_sqr);
                    if (w_e_last) begin
                        r_state <= S_USQ0;
                    end else begin
                        r_e     <= r_e + 1'b1;
                        r_state <= S_URD;
                    end
                end
                S_USQ0: begin
                    r_state <= S_USQRT;
                end
                S_USQRT: begin
                    if (w_sqrt_done) begin
                        r_shift <= r_shift + klc_pkg::SH_W'(w_root);
                        r_c     <= r_c + 1'b1;
                        r_state <= S_UCHK;
                    end
                end
                S_ITEREND: begin
                    r_iter <= w_iter_nx;
                    if (w_stable || (w_iter_nx >= w_lim)) begin
                        r_conv <= w_stable;
                        r_c    <= '0;
                        r_surv <= '0;
                        for (int i = 0; i < klc_pkg::MAX_CLUSTERS; i++) begin
                            r_map[i] <= '0;
                        end
                        r_state <= S_COMPACT;
                    end else begin
                        r_clr   <= '0;
                        r_state <= S_CLR;
                    end
                end
                S_COMPACT: begin
                    if ({1'b0, r_c} == {1'b0, w_k}) begin
                        r_res_cv <= '0;
                        r_state  <= S_EMIT;
                    end else begin
                        if (r_alive[r_c[klc_pkg::C_W-1:0]]) begin
                            r_map[r_surv[klc_pkg::C_W-1:0]] <= r_c[klc_pkg::C_W-1:0];
                            r_surv <= r_surv + 1'b1;
                        end
                        r_c <= r_c + 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    `KLC_ASSERT_IMP(a_div_done_in_wait, i_clk, i_rst_n, w_div_done, r_state == S_UDIV)
    `KLC_ASSERT_IMP(a_sqrt_done_in_wait, i_clk, i_rst_n, w_sqrt_done, r_state == S_USQRT)
    `KLC_ASSERT_IMP(a_pick_live_centre, i_clk, i_rst_n, r_state == S_DPICK,
        ({1'b0, r_c} < {1'b0, w_k}) && r_alive[r_c[klc_pkg::C_W-1:0]])
    `KLC_ASSERT_NXT(a_emit_sets_valid, i_clk, i_rst_n, w_emit,
        o_m_axis_tvalid && (r_state == S_IDLE))

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    typedef struct {
        bit          is_cfg;
        logic [1:0]  cmd;
        logic [9:0]  pidx;
        logic [3:0]  cidx;
        logic [6:0]  didx;
        logic [15:0] val;
        logic [2:0]  reg_idx;
        logic [15:0] reg_data;
    } t_beat;

    typedef struct {
        logic [15:0] centre_value;
        logic [7:0]  iterations;
        logic [4:0]  survivors;
        logic        converged;
    } t_answer;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [39:0] s_data = '0;
    logic [1:0]  s_user = '0;
    logic        m_ready = 1'b0;
    logic        c_valid = 1'b0;
    logic [2:0]  c_index = '0;
    logic [15:0] c_data = '0;
    logic        o_s_axis_tready, o_m_axis_tvalid, o_cfg_ready;
    logic [31:0] o_m_axis_tdata;

    kmeans_lloyd_clustering_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (c_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (c_index),
        .i_cfg_data      (c_data)
    );

    always #4 i_clk = ~i_clk;

    t_beat   pend_q[$];
    t_answer answer_q[$];
    t_beat   cur;
    int      errors = 0;
    int      n_runs = 0, n_reads = 0, n_loads = 0, n_cfg = 0;
    int      cyc = 0;
    int      quiet = 0;
    bit      s_fire = 1'b0, c_fire = 1'b0;
    bit      calm;

    // model state
    logic signed [15:0] pt_mem [klc_pkg::PT_DEPTH];
    logic signed [15:0] ct_mem [klc_pkg::CT_DEPTH];
    bit          alive [klc_pkg::MAX_CLUSTERS];
    logic [3:0]  cmap [klc_pkg::MAX_CLUSTERS];
    logic [7:0]  last_iters;
    logic [4:0]  survivors;
    logic        conv_flag;
    logic [4:0]  k_reg;
    logic [7:0]  d_reg;
    logic [10:0] n_reg;
    logic [15:0] thr_reg;
    logic [7:0]  it_reg;

    // stimulus shadow
    bit          g_pw [klc_pkg::PT_DEPTH];
    bit          g_cw [klc_pkg::CT_DEPTH];
    logic [4:0]  g_k = 5'd8;
    logic [7:0]  g_d = 8'd128;
    logic [10:0] g_n = 11'd1024;
    int          g_klast = 0;
    int          item_total = 0;

    assign calm = (cyc % 40000) >= 30000;

    function automatic int clampi(int v, int lo, int hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint unsigned rounded_root(longint unsigned s);
        longint unsigned r, t;
        r = 0;
        for (int b = 23; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= s) r = t;
        end
        return (s - r * r > r) ? r + 1 : r;
    endfunction

    task automatic cluster_points();
        int k, d, n, lim, iter, best;
        longint unsigned best_d, sqdist, shift_sum, sq;
        longint sums [klc_pkg::CT_DEPTH];
        int cnt [klc_pkg::MAX_CLUSTERS];
        longint df, m;
        bit stable;
        k = clampi(k_reg, 1, klc_pkg::MAX_CLUSTERS);
        d = clampi(d_reg, 1, klc_pkg::MAX_DIMS);
        n = clampi(n_reg, 1, klc_pkg::MAX_POINTS);
        lim = clampi(it_reg, 1, 255);
        iter = 0;
        for (int c = 0; c < klc_pkg::MAX_CLUSTERS; c++) alive[c] = c < k;
        do begin
            shift_sum = 0;
            for (int i = 0; i < klc_pkg::CT_DEPTH; i++) sums[i] = 0;
            for (int c = 0; c < klc_pkg::MAX_CLUSTERS; c++) cnt[c] = 0;
            for (int p = 0; p < n; p++) begin
                best = -1;
                best_d = 0;
                for (int c = 0; c < k; c++) begin
                    if (!alive[c]) continue;
                    sqdist = 0;
                    for (int e = 0; e < d; e++) begin
                        df = longint'(pt_mem[p*klc_pkg::MAX_DIMS+e])
                           - longint'(ct_mem[c*klc_pkg::MAX_DIMS+e]);
                        sqdist += df * df;
                    end
                    if (best < 0 || sqdist < best_d) begin
                        best = c;
                        best_d = sqdist;
                    end
                end
                if (best < 0) continue;
                cnt[best]++;
                for (int e = 0; e < d; e++)
                    sums[best*klc_pkg::MAX_DIMS+e] += pt_mem[p*klc_pkg::MAX_DIMS+e];
            end
            for (int c = 0; c < k; c++) begin
                if (!alive[c]) continue;
                if (cnt[c] == 0) begin
                    alive[c] = 1'b0;
                    shift_sum += 100000;
                    continue;
                end
                sq = 0;
                for (int e = 0; e < d; e++) begin
                    m = sums[c*klc_pkg::MAX_DIMS+e] / longint'(cnt[c]);
                    df = m - longint'(ct_mem[c*klc_pkg::MAX_DIMS+e]);
                    sq += df * df;
                    ct_mem[c*klc_pkg::MAX_DIMS+e] = m[15:0];
                end
                shift_sum += rounded_root(sq);
            end
            iter++;
            stable = shift_sum <= longint'(thr_reg) * k;
        end while (!stable && iter < lim);
        survivors = 0;
        for (int c = 0; c < klc_pkg::MAX_CLUSTERS; c++) cmap[c] = 0;
        for (int c = 0; c < k; c++)
            if (alive[c]) begin
                cmap[survivors] = 4'(c);
                survivors++;
            end
        last_iters = iter[7:0];
        conv_flag = stable;
    endtask

    task automatic predict_beat(t_beat b);
        t_answer a;
        case (b.cmd)
            klc_pkg::CMD_LOAD_PT: begin
                pt_mem[b.pidx*klc_pkg::MAX_DIMS+b.didx] = b.val;
                n_loads++;
            end
            klc_pkg::CMD_LOAD_CT: begin
                ct_mem[b.cidx*klc_pkg::MAX_DIMS+b.didx] = b.val;
                n_loads++;
            end
            default: begin
                a.centre_value = '0;
                if (b.cmd == klc_pkg::CMD_RUN) begin
                    cluster_points();
                    n_runs++;
                end else begin
                    n_reads++;
                    if (b.cidx < survivors && b.didx < clampi(d_reg, 1, klc_pkg::MAX_DIMS))
                        a.centre_value = ct_mem[cmap[b.cidx]*klc_pkg::MAX_DIMS+b.didx];
                end
                a.iterations = last_iters;
                a.survivors = survivors;
                a.converged = conv_flag;
                answer_q = {answer_q, a};
            end
        endcase
    endtask

    task automatic apply_reg(logic [2:0] idx, logic [15:0] data);
        n_cfg++;
        case (idx)
            klc_pkg::REG_NUM_CLUSTERS:   k_reg = data[4:0];
            klc_pkg::REG_NUM_DIMS:       d_reg = data[7:0];
            klc_pkg::REG_NUM_POINTS:     n_reg = data[10:0];
            klc_pkg::REG_STOP_THRESHOLD: thr_reg = data;
            klc_pkg::REG_MAX_ITERATIONS: it_reg = data[7:0];
            default: ;
        endcase
    endtask

    task automatic report(string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        errors++;
    endtask

    // stimulus helpers
    task automatic add_cfg(logic [2:0] idx, logic [15:0] data);
        t_beat b;
        b = '{default: '0};
        b.is_cfg = 1'b1;
        b.reg_idx = idx;
        b.reg_data = data;
        pend_q = {pend_q, b};
        case (idx)
            klc_pkg::REG_NUM_CLUSTERS: g_k = data[4:0];
            klc_pkg::REG_NUM_DIMS:     g_d = data[7:0];
            klc_pkg::REG_NUM_POINTS:   g_n = data[10:0];
            default: ;
        endcase
    endtask

    task automatic add_item(logic [1:0] cmd, int p, int c, int e, logic [15:0] v);
        t_beat b;
        b = '{default: '0};
        b.cmd = cmd;
        b.pidx = 10'(p);
        b.cidx = 4'(c);
        b.didx = 7'(e);
        b.val = v;
        pend_q = {pend_q, b};
        item_total++;
        if (cmd == klc_pkg::CMD_LOAD_PT) g_pw[p*klc_pkg::MAX_DIMS+e] = 1'b1;
        if (cmd == klc_pkg::CMD_LOAD_CT) g_cw[c*klc_pkg::MAX_DIMS+e] = 1'b1;
    endtask

    task automatic add_read(int c, int e);
        bit safe;
        safe = 1'b1;
        if (g_klast > 0 && e < clampi(g_d, 1, klc_pkg::MAX_DIMS))
            for (int i = 0; i < g_klast; i++)
                if (!g_cw[i*klc_pkg::MAX_DIMS+e]) safe = 1'b0;
        add_item(klc_pkg::CMD_READ, $urandom_range(0, 1023), c, safe ? e : 0, 16'($urandom));
    endtask

    task automatic load_and_run(bit fresh, int spread);
        int k, d, n, nb;
        logic [15:0] bases [4][klc_pkg::MAX_DIMS];
        logic [15:0] v;
        k = clampi(g_k, 1, klc_pkg::MAX_CLUSTERS);
        d = clampi(g_d, 1, klc_pkg::MAX_DIMS);
        n = clampi(g_n, 1, klc_pkg::MAX_POINTS);
        nb = $urandom_range(1, 4);
        for (int i = 0; i < 4; i++)
            for (int e = 0; e < d; e++) bases[i][e] = 16'($urandom);
        for (int p = 0; p < n; p++)
            for (int e = 0; e < d; e++)
                if (fresh || !g_pw[p*klc_pkg::MAX_DIMS+e]) begin
                    v = bases[p % nb][e] + 16'($urandom_range(0, 2*spread) - spread);
                    add_item(klc_pkg::CMD_LOAD_PT, p, 0, e, v);
                end
        for (int c = 0; c < k; c++)
            for (int e = 0; e < d; e++)
                if (fresh || !g_cw[c*klc_pkg::MAX_DIMS+e]) begin
                    v = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                    : bases[c % nb][e] + 16'($urandom_range(0, 511));
                    add_item(klc_pkg::CMD_LOAD_CT, 0, c, e, v);
                end
        add_item(klc_pkg::CMD_RUN, $urandom_range(0, 1023), $urandom_range(0, 15),
                 $urandom_range(0, 127), 16'($urandom));
        g_klast = k;
    endtask

    task automatic set_all(int k, int d, int n, int thr, int it);
        add_cfg(klc_pkg::REG_NUM_CLUSTERS, 16'(k));
        add_cfg(klc_pkg::REG_NUM_DIMS, 16'(d));
        add_cfg(klc_pkg::REG_NUM_POINTS, 16'(n));
        add_cfg(klc_pkg::REG_STOP_THRESHOLD, 16'(thr));
        add_cfg(klc_pkg::REG_MAX_ITERATIONS, 16'(it));
    endtask

    initial begin
        int k, d, n, thr, it;
        // read before any run
        add_read(0, 0);
        set_all(2, 1, 2, 0, 3);
        add_item(klc_pkg::CMD_LOAD_PT, 0, 0, 0, 16'h7fff);
        add_item(klc_pkg::CMD_LOAD_PT, 1, 0, 0, 16'h8000);
        add_item(klc_pkg::CMD_LOAD_CT, 0, 0, 0, 16'h0000);
        add_item(klc_pkg::CMD_LOAD_CT, 0, 1, 0, 16'h0000);
        // tied centres: lowest index wins, the other dies
        add_item(klc_pkg::CMD_RUN, 0, 0, 0, 16'h0);
        add_read(0, 0);
        add_read(1, 0);
        add_read(0, 5);
        add_item(klc_pkg::CMD_LOAD_PT, 0, 0, 0, 16'h0000);
        add_item(klc_pkg::CMD_LOAD_CT, 0, 0, 0, 16'hff00);
        add_item(klc_pkg::CMD_LOAD_CT, 0, 1, 0, 16'h0100);
        add_item(klc_pkg::CMD_RUN, 0, 0, 0, 16'h0);
        add_read(1, 0);
        add_item(klc_pkg::CMD_LOAD_PT, 1023, 0, 127, 16'hffff);
        add_item(klc_pkg::CMD_LOAD_CT, 0, 15, 127, 16'h8000);
        // saturated register values
        set_all(31, 0, 0, 16'hffff, 0);
        load_and_run(1'b1, 8);
        add_read(0, 0);
        set_all(0, 255, 2047, 0, 255);
        add_read(15, 127);
        // widest vectors, then the most points
        set_all(1, 128, 1, 0, 2);
        load_and_run(1'b1, 100);
        add_read(0, 127);
        set_all(1, 1, 1024, 65535, 1);
        load_and_run(1'b0, 300);
        add_read(0, 0);
        set_all(16, 2, 20, 256, 4);
        load_and_run(1'b1, 50);
        add_read(15, 1);

        while (item_total < 1500) begin
            k = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 5);
            d = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
            n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
            it = $urandom_range(1, 6);
            thr = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 600);
            if ($urandom_range(0, 7) == 0) begin
                d = 1;
                thr = 65535;
                it = 255;
            end else if ($urandom_range(0, 7) == 0) begin
                it = 0;
            end
            set_all(k, d, n, thr, it);
            repeat ($urandom_range(1, 3)) begin
                repeat ($urandom_range(0, 4))
                    add_item($urandom_range(0, 1) ? klc_pkg::CMD_LOAD_PT : klc_pkg::CMD_LOAD_CT,
                             $urandom_range(0, 1023), $urandom_range(0, 15),
                             $urandom_range(0, 127), 16'($urandom));
                load_and_run($urandom_range(0, 3) != 0,
                             $urandom_range(0, 1) ? $urandom_range(0, 400) : 32767);
                repeat ($urandom_range(1, 6))
                    add_read($urandom_range(0, 15),
                             $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 127));
            end
        end
    end

    initial begin
        k_reg = 5'd8;
        d_reg = 8'd128;
        n_reg = 11'd1024;
        thr_reg = 16'd256;
        it_reg = 8'd100;
        last_iters = '0;
        survivors = '0;
        conv_flag = 1'b0;
        for (int c = 0; c < klc_pkg::MAX_CLUSTERS; c++) begin
            alive[c] = 1'b1;
            cmap[c] = '0;
        end
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
    end

    always @(posedge i_clk) begin
        t_answer a;
        logic [15:0] g_cv;
        cyc <= cyc + 1;
        s_fire <= s_valid && o_s_axis_tready;
        c_fire <= c_valid && o_cfg_ready;
        if (i_rst_n) begin
            if (s_valid && o_s_axis_tready) predict_beat(cur);
            if (c_valid && o_cfg_ready) apply_reg(c_index, c_data);
            if (o_m_axis_tvalid && m_ready) begin
                g_cv = o_m_axis_tdata[15:0];
                if (answer_q.size() == 0) begin
                    report($sformatf("unexpected result %h", o_m_axis_tdata));
                end else begin
                    a = answer_q.pop_front();
                    if (g_cv !== a.centre_value)
                        report($sformatf("centre_value %h, want %h", g_cv, a.centre_value));
                    if (o_m_axis_tdata[23:16] !== a.iterations)
                        report($sformatf("iterations %0d, want %0d",
                                         o_m_axis_tdata[23:16], a.iterations));
                    if (o_m_axis_tdata[28:24] !== a.survivors)
                        report($sformatf("surviving_clusters %0d, want %0d",
                                         o_m_axis_tdata[28:24], a.survivors));
                    if (o_m_axis_tdata[29] !== a.converged)
                        report($sformatf("converged %b, want %b",
                                         o_m_axis_tdata[29], a.converged));
                end
            end
        end
    end

    always @(negedge i_clk) begin
        bit sv, cv;
        t_beat b;
        m_ready <= calm || ($urandom_range(0, 99) >= 30);
        if (i_rst_n) begin
            sv = s_valid && !s_fire;
            cv = c_valid && !c_fire;
            if (s_fire || c_fire) quiet = 0;
            else if (quiet < 1000) quiet++;
            if (!sv && !cv && pend_q.size() > 0) begin
                if (pend_q[0].is_cfg) begin
                    if (answer_q.size() == 0 && quiet >= 8) begin
                        b = pend_q.pop_front();
                        cv = 1'b1;
                        c_index <= b.reg_idx;
                        c_data <= b.reg_data;
                    end
                end else if (calm || $urandom_range(0, 99) >= 30) begin
                    b = pend_q.pop_front();
                    cur = b;
                    sv = 1'b1;
                    s_data <= {3'b000, b.val, b.didx, b.cidx, b.pidx};
                    s_user <= b.cmd;
                end
            end
            s_valid <= sv;
            c_valid <= cv;
        end
    end

    initial begin
        @(posedge i_rst_n);
        while (pend_q.size() > 0 || s_valid || c_valid || answer_q.size() > 0)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (answer_q.size() > 0) report($sformatf("%0d results never arrived", answer_q.size()));
        $display("Covered %0d loads, %0d runs, %0d reads and %0d register writes.",
                 n_loads, n_runs, n_reads, n_cfg);
        if (errors == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #400_000_000;
        $display("Timeout with %0d beats pending", pend_q.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
